// ===== hdl/pedm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pedm_pkg
// shared constants and types for the prewitt edge-direction mask core
// ----------------------------------------------------------------------------
package pedm_pkg;

  // frame size limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;

  // register field widths
  localparam int WID_W  = 12;
  localparam int HGT_W  = 13;
  localparam int DATA_W = 13;
  localparam int IDX_W  = 4;

  // register reset values
  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;

  // register indexes
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = IDX_W'(1);

  // stream position and line store geometry
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int HW_W  = $clog2(MAX_WIDTH + 1);

  // one line store entry holds {middle cell, upper cell}, 2 bits each
  localparam int CELL_W  = 2;
  localparam int ENTRY_W = 2 * CELL_W;
  localparam int WIN_W   = 9 * CELL_W;

  localparam logic [7:0] GREY_MID = 8'd128;
  localparam logic [7:0] MAG_MAX  = 8'd255;

  // item in flight between the line store read and the output register
  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [CELL_W-1:0]  pix;
    logic               produce;
    logic               border;
    logic               done;
    logic               rd_valid;
    logic               fwd;
    logic [ENTRY_W-1:0] fwd_data;
  } stage_t;

endpackage
`default_nettype wire

// ===== hdl/pedm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pedm_ram
// simple dual-port ram, one write port, one registered read port (read-first)
// ----------------------------------------------------------------------------
module pedm_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/prewitt_edge_direction_masks_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prewitt_edge_direction_masks_core
// prewitt x/y edge magnitudes and direction masks over a binarized grey stream
// ----------------------------------------------------------------------------
// The core takes one grey pixel per clock in raster order, unless the output
// stalls, and turns it into a dark bit (grey below 128) and a bright bit (grey
// above 128). Both line stores live in one 2048 x 4 ram, read at the pixel's
// column when the item is accepted and written back as it leaves stage 1,
// when its result enters the output register. Results lag the pixels by
// width+1 items: after each frame, feed width+1 flush items (is_pad high) to
// push out the last row; frame_done marks the result of the last pixel.
// Border pixels give zero magnitudes and masks equal to their bright bit.
// Writing image_width or image_height restarts the frame position; values
// are clamped to 3..2048 and 3..4096. The line stores need no clearing pass
// after reset: a high-water count of written columns makes untouched
// entries read as zero.
// ----------------------------------------------------------------------------
module prewitt_edge_direction_masks_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // pixel input
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic [7:0]                  in_grey_level,
  input  wire logic                        in_is_pad,
  // result output
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [7:0]                  out_horiz_magnitude,
  output      logic [7:0]                  out_vert_magnitude,
  output      logic                        out_vertical_only_mask,
  output      logic                        out_horizontal_only_mask,
  output      logic                        out_frame_done,
  // register writes
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [pedm_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [pedm_pkg::DATA_W-1:0] cfg_data
);

  localparam int COL_W   = pedm_pkg::COL_W;
  localparam int ROW_W   = pedm_pkg::ROW_W;
  localparam int HW_W    = pedm_pkg::HW_W;
  localparam int WID_W   = pedm_pkg::WID_W;
  localparam int HGT_W   = pedm_pkg::HGT_W;
  localparam int ENTRY_W = pedm_pkg::ENTRY_W;
  localparam int CELL_W  = pedm_pkg::CELL_W;
  localparam int WIN_W   = pedm_pkg::WIN_W;

  // effective (clamped) frame size
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;

  // stream position of the next item
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // columns 0 .. hw_r-1 of the line stores have been written
  logic [HW_W-1:0] hw_r;

  logic [WIN_W-1:0] win_r, win_nxt;

  pedm_pkg::stage_t s1_r, s1_nxt;
  logic             s1_valid_r;

  logic             out_valid_r;
  logic [7:0]       hmag_r, vmag_r;
  logic             vmask_r, hmask_r, done_r;

  logic                   cfg_wr;
  logic                   cfg_hit;
  logic [WID_W-1:0]       cfg_w;
  logic [HGT_W-1:0]       cfg_h;
  logic                   in_accept;
  logic                   out_free;
  logic                   s1_adv;
  logic                   hold;
  logic [COL_W-1:0]       rd_addr;
  logic [ENTRY_W-1:0]     rd_data;
  logic [ENTRY_W-1:0]     entry;
  logic [ENTRY_W-1:0]     wr_data;
  logic [CELL_W-1:0]      pix_bits;
  logic [WID_W-1:0]       col_inc;
  logic [ROW_W-1:0]       last_row;
  logic [ROW_W-1:0]       h_ext;
  logic                   col_zero;
  logic                   col_one;
  logic                   row_is_last;
  logic                   produce;
  logic                   q_top;
  logic                   q_bottom;
  logic [1:0]             dk_left, dk_right, dk_top, dk_bot;
  logic                   gx_nz, gy_nz, bright;
  logic [7:0]             hmag_nxt, vmag_nxt;
  logic                   vmask_nxt, hmask_nxt;

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  // only writes to a listed register restart the frame position
  assign cfg_hit   = cfg_wr && (cfg_index inside {pedm_pkg::REG_IMAGE_WIDTH,
                                                  pedm_pkg::REG_IMAGE_HEIGHT});

  // output register can take a new item this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign hold      = s1_valid_r && !out_free;
  assign in_stall  = hold;
  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // configuration registers, clamped on write
  // --------------------------------------------------------------------------
  always_comb begin
    cfg_w = cfg_data[WID_W-1:0];
    if (cfg_w < WID_W'(pedm_pkg::MIN_DIM)) begin
      cfg_w = WID_W'(pedm_pkg::MIN_DIM);
    end else if (cfg_w > WID_W'(pedm_pkg::MAX_WIDTH)) begin
      cfg_w = WID_W'(pedm_pkg::MAX_WIDTH);
    end
    cfg_h = cfg_data[HGT_W-1:0];
    if (cfg_h < HGT_W'(pedm_pkg::MIN_DIM)) begin
      cfg_h = HGT_W'(pedm_pkg::MIN_DIM);
    end else if (cfg_h > HGT_W'(pedm_pkg::MAX_HEIGHT)) begin
      cfg_h = HGT_W'(pedm_pkg::MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WID_W'(pedm_pkg::RST_WIDTH);
      height_r <= HGT_W'(pedm_pkg::RST_HEIGHT);
    end else if (cfg_wr) begin
      case (cfg_index)
        pedm_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_w;
        pedm_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_h;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: position, result bookkeeping, line store read
  // --------------------------------------------------------------------------
  always_comb begin
    pix_bits = '0;
    if (!in_is_pad) begin
      pix_bits[0] = in_grey_level < pedm_pkg::GREY_MID;
      pix_bits[1] = in_grey_level > pedm_pkg::GREY_MID;
    end
  end

  assign col_inc     = WID_W'(col_r) + WID_W'(1);
  assign h_ext       = ROW_W'(height_r);
  assign last_row    = h_ext + ROW_W'(1);
  assign col_zero    = col_r == '0;
  assign col_one     = col_r == COL_W'(1);
  assign row_is_last = row_r == last_row;

  // results start at row 1 column 1 and run to the frame's last flush slot
  assign produce  = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && !col_zero);
  // result row is the first or the last row of the frame
  assign q_top    = ((row_r == ROW_W'(1)) && !col_zero) ||
                    ((row_r == ROW_W'(2)) && col_zero);
  assign q_bottom = ((row_r == h_ext) && !col_zero) || (row_is_last && col_zero);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_accept) begin
      if (row_is_last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc == width_r) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_hit) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // while the stage is held, re-read its own column so the read data stays
  assign rd_addr = hold ? s1_r.col : col_r;

  always_comb begin
    s1_nxt          = s1_r;
    s1_nxt.col      = col_r;
    s1_nxt.pix      = pix_bits;
    s1_nxt.produce  = produce;
    // left column is col 1 (q at col 0), right column is col 0 (q at w-1)
    s1_nxt.border   = q_top || q_bottom || col_zero || col_one;
    s1_nxt.done     = row_is_last && col_zero;
    s1_nxt.rd_valid = HW_W'(col_r) < hw_r;
    // back-to-back access to the same column at the frame wrap
    s1_nxt.fwd      = s1_adv && (s1_r.col == col_r);
    s1_nxt.fwd_data = wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= s1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // line stores: entry = {middle cell, upper cell}
  // --------------------------------------------------------------------------
  pedm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (pedm_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_r.col),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // never-written columns read as zero
  always_comb begin
    if (s1_r.fwd) begin
      entry = s1_r.fwd_data;
    end else if (s1_r.rd_valid) begin
      entry = rd_data;
    end else begin
      entry = '0;
    end
  end

  // shift the column down: middle becomes upper, new cell becomes middle
  assign wr_data = {s1_r.pix, entry[ENTRY_W-1:CELL_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= '0;
    end else if (s1_adv && (HW_W'(s1_r.col) == hw_r)) begin
      hw_r <= hw_r + HW_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: window shift and gradients
  // --------------------------------------------------------------------------
  // window bit 6*k + 2*j + b: column k (0 oldest), row j (0 top), b bright
  assign win_nxt = {s1_r.pix, entry, win_r[WIN_W-1:3*CELL_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  // counts of dark bits on each side of the window
  assign dk_left  = 2'(win_nxt[0])  + 2'(win_nxt[2])  + 2'(win_nxt[4]);
  assign dk_right = 2'(win_nxt[12]) + 2'(win_nxt[14]) + 2'(win_nxt[16]);
  assign dk_top   = 2'(win_nxt[0])  + 2'(win_nxt[6])  + 2'(win_nxt[12]);
  assign dk_bot   = 2'(win_nxt[4])  + 2'(win_nxt[10]) + 2'(win_nxt[16]);
  assign bright   = win_nxt[9];

  // any nonzero gradient is at least 255, so twice it saturates
  assign gx_nz = dk_left != dk_right;
  assign gy_nz = dk_top != dk_bot;

  always_comb begin
    if (s1_r.border) begin
      hmag_nxt  = '0;
      vmag_nxt  = '0;
      vmask_nxt = bright;
      hmask_nxt = bright;
    end else begin
      hmag_nxt  = gy_nz ? pedm_pkg::MAG_MAX : '0;
      vmag_nxt  = gx_nz ? pedm_pkg::MAG_MAX : '0;
      vmask_nxt = gx_nz && !gy_nz;
      if (gx_nz) begin
        hmask_nxt = 1'b0;
      end else if (gy_nz) begin
        hmask_nxt = 1'b1;
      end else begin
        hmask_nxt = bright;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && s1_r.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      hmag_r  <= hmag_nxt;
      vmag_r  <= vmag_nxt;
      vmask_r <= vmask_nxt;
      hmask_r <= hmask_nxt;
      done_r  <= s1_r.done;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_horiz_magnitude      = hmag_r;
  assign out_vert_magnitude       = vmag_r;
  assign out_vertical_only_mask   = vmask_r;
  assign out_horizontal_only_mask = hmask_r;
  assign out_frame_done           = done_r;

endmodule
`default_nettype wire

// ===== tb/prewitt_edge_direction_masks_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prewitt_edge_direction_masks_checker
// watches the pixel, result and register channels of the edge mask core,
// predicts every result from its own copy of the line stores and window and
// compares each one field by field in order of arrival
// ----------------------------------------------------------------------------
module prewitt_edge_direction_masks_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [7:0]                  in_grey_level,
  input  wire logic                        in_is_pad,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [7:0]                  out_horiz_magnitude,
  input  wire logic [7:0]                  out_vert_magnitude,
  input  wire logic                        out_vertical_only_mask,
  input  wire logic                        out_horizontal_only_mask,
  input  wire logic                        out_frame_done,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic [pedm_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [pedm_pkg::DATA_W-1:0] cfg_data,
  input  wire logic                        end_check,
  output int                               fail_count,
  output int                               pending_results,
  output int                               pixels_taken,
  output int                               results_taken,
  output int                               frame_ends,
  output int                               reg_writes
);

  localparam int PRINT_CAP = 50;

  typedef struct packed {
    logic [7:0] horiz_mag;
    logic [7:0] vert_mag;
    logic       vert_only;
    logic       horiz_only;
    logic       last_pixel;
  } edge_result_t;

  edge_result_t edge_results_due[$];

  logic [pedm_pkg::WID_W-1:0] width_reg;
  logic [pedm_pkg::HGT_W-1:0] height_reg;
  logic [1:0]                 upper_line  [pedm_pkg::MAX_WIDTH];
  logic [1:0]                 middle_line [pedm_pkg::MAX_WIDTH];
  logic [17:0]                window;
  int                         col_pos;
  int                         row_pos;

  initial begin
    fail_count      = 0;
    pending_results = 0;
    pixels_taken    = 0;
    results_taken   = 0;
    frame_ends      = 0;
    reg_writes      = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                results_taken, name, got, want));
  endtask

  // twice the absolute gradient, saturated
  function automatic logic [7:0] sat_twice_abs(input int grad);
    int mag;
    mag = 2 * 255 * ((grad < 0) ? -grad : grad);
    return (mag > 255) ? pedm_pkg::MAG_MAX : 8'(mag);
  endfunction

  task automatic predict_edge_result(input logic [7:0] grey, input logic pad);
    int           w;
    int           h;
    int           n;
    int           q;
    int           gx;
    int           gy;
    logic [1:0]   pix;
    logic         bright;
    edge_result_t res;
    w = int'(width_reg);
    h = int'(height_reg);
    if (w < pedm_pkg::MIN_DIM) w = pedm_pkg::MIN_DIM;
    if (w > pedm_pkg::MAX_WIDTH) w = pedm_pkg::MAX_WIDTH;
    if (h < pedm_pkg::MIN_DIM) h = pedm_pkg::MIN_DIM;
    if (h > pedm_pkg::MAX_HEIGHT) h = pedm_pkg::MAX_HEIGHT;
    if (col_pos >= w) col_pos = 0;
    if (row_pos > h + 1) row_pos = 0;

    // {bright, dark}, both zero for a pad or a grey of exactly mid level
    pix = pad ? 2'b00 : {grey > pedm_pkg::GREY_MID, grey < pedm_pkg::GREY_MID};
    window = {pix, middle_line[col_pos], upper_line[col_pos], window[17:6]};
    upper_line[col_pos]  = middle_line[col_pos];
    middle_line[col_pos] = pix;

    n = row_pos * w + col_pos;
    if (n >= w + 1 && n - (w + 1) < w * h) begin
      q      = n - (w + 1);
      bright = window[9];
      if (q / w == 0 || q / w == h - 1 || q % w == 0 || q % w == w - 1) begin
        res.horiz_mag  = 8'd0;
        res.vert_mag   = 8'd0;
        res.vert_only  = bright;
        res.horiz_only = bright;
      end else begin
        gx = 0;
        gy = 0;
        for (int j = 0; j < 3; j++) gx += int'(window[2*j]) - int'(window[12+2*j]);
        for (int k = 0; k < 3; k++) gy += int'(window[6*k]) - int'(window[6*k+4]);
        res.horiz_mag = sat_twice_abs(gy);
        res.vert_mag  = sat_twice_abs(gx);
        res.vert_only = (res.vert_mag == pedm_pkg::MAG_MAX) &&
                        (res.horiz_mag != pedm_pkg::MAG_MAX);
        if (res.vert_mag == pedm_pkg::MAG_MAX) res.horiz_only = 1'b0;
        else if (res.horiz_mag == pedm_pkg::MAG_MAX) res.horiz_only = 1'b1;
        else res.horiz_only = bright;
      end
      res.last_pixel = (q == w * h - 1);
      edge_results_due = {edge_results_due, res};
    end

    // the flush tail ends on row h+1, then the frame starts over
    if (row_pos == h + 1) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      col_pos++;
      if (col_pos == w) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    edge_result_t due;
    if (!rst_n) begin
      width_reg  = pedm_pkg::WID_W'(pedm_pkg::RST_WIDTH);
      height_reg = pedm_pkg::HGT_W'(pedm_pkg::RST_HEIGHT);
      for (int i = 0; i < pedm_pkg::MAX_WIDTH; i++) begin
        upper_line[i]  = 2'b00;
        middle_line[i] = 2'b00;
      end
      window  = '0;
      col_pos = 0;
      row_pos = 0;
      edge_results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_taken++;
        if (edge_results_due.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    results_taken));
        end else begin
          due = edge_results_due.pop_front();
          check_field("horiz_magnitude", out_horiz_magnitude, due.horiz_mag);
          check_field("vert_magnitude", out_vert_magnitude, due.vert_mag);
          check_field("vertical_only_mask", out_vertical_only_mask, due.vert_only);
          check_field("horizontal_only_mask", out_horizontal_only_mask, due.horiz_only);
          check_field("frame_done", out_frame_done, due.last_pixel);
          if (due.last_pixel) frame_ends++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        if (cfg_index == pedm_pkg::REG_IMAGE_WIDTH) begin
          width_reg = cfg_data[pedm_pkg::WID_W-1:0];
          col_pos   = 0;
          row_pos   = 0;
        end else if (cfg_index == pedm_pkg::REG_IMAGE_HEIGHT) begin
          height_reg = cfg_data[pedm_pkg::HGT_W-1:0];
          col_pos    = 0;
          row_pos    = 0;
        end
      end
      if (in_valid && !in_stall) begin
        pixels_taken++;
        predict_edge_result(in_grey_level, in_is_pad);
      end
    end
    pending_results = edge_results_due.size();
  end

  always @(posedge end_check)
    if (edge_results_due.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                edge_results_due.size()));

endmodule

// ===== tb/tb_prewitt_edge_direction_masks_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prewitt_edge_direction_masks_core
// pixel stream stimulus and verdict for the prewitt edge mask core; a checker
// beside the core predicts and compares every result, this top drives frames
// of many geometries under changing idle and stall patterns
// ----------------------------------------------------------------------------
module tb_prewitt_edge_direction_masks_core;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 10;
  // flush items push out the last row's results, so leave a margin after the
  // last one before touching registers
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  // random frames make up the rest of the items after the directed parts
  localparam int RANDOM_ITEMS  = 320;
  // slowest correct stretch without a handshake is the long output hold-off
  // plus a few random gaps; take that many times over
  localparam int STUCK_LIMIT   = 4000;

  // directed frame, 5 wide and 3 high, then its 6 flush slots; {pad, grey}
  localparam logic [0:20][8:0] DIRECTED_ITEMS = {
    9'h000, 9'h000, 9'h0FF, 9'h0FF, 9'h081,   // row 0: just above mid level
    9'h000, 9'h080, 9'h0FF, 9'h000, 9'h0FF,   // row 1: exactly mid level
    9'h000, 9'h07F, 9'h0FF, 9'h000, 9'h100,   // row 2: pad inside the frame
    9'h1FF, 9'h000, 9'h100, 9'h07F, 9'h1FF,   // flush: pads and stray pixels
    9'h100
  };

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [7:0]                  in_grey_level = 8'd0;
  logic                        in_is_pad = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [7:0]                  out_horiz_magnitude;
  logic [7:0]                  out_vert_magnitude;
  logic                        out_vertical_only_mask;
  logic                        out_horizontal_only_mask;
  logic                        out_frame_done;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [pedm_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [pedm_pkg::DATA_W-1:0] cfg_data = '0;
  logic                        end_check = 1'b0;

  int          fail_count;
  int          pending_results;
  int          pixels_taken;
  int          results_taken;
  int          frame_ends;
  int          reg_writes;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          pushed_items = 0;
  int          stuck_cycles = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  prewitt_edge_direction_masks_core u_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_grey_level            (in_grey_level),
    .in_is_pad                (in_is_pad),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_horiz_magnitude      (out_horiz_magnitude),
    .out_vert_magnitude       (out_vert_magnitude),
    .out_vertical_only_mask   (out_vertical_only_mask),
    .out_horizontal_only_mask (out_horizontal_only_mask),
    .out_frame_done           (out_frame_done),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data)
  );

  prewitt_edge_direction_masks_checker u_checker (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_grey_level            (in_grey_level),
    .in_is_pad                (in_is_pad),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_horiz_magnitude      (out_horiz_magnitude),
    .out_vert_magnitude       (out_vert_magnitude),
    .out_vertical_only_mask   (out_vertical_only_mask),
    .out_horizontal_only_mask (out_horizontal_only_mask),
    .out_frame_done           (out_frame_done),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .end_check                (end_check),
    .fail_count               (fail_count),
    .pending_results          (pending_results),
    .pixels_taken             (pixels_taken),
    .results_taken            (results_taken),
    .frame_ends               (frame_ends),
    .reg_writes               (reg_writes)
  );

  // result side: one long hold-off on request, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("no handshake for %0d cycles", STUCK_LIMIT);
      $display("tb_prewitt_edge_direction_masks_core NOT OK");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // mid level, both extremes and plain random greys
  function automatic logic [7:0] pick_grey();
    case ($urandom_range(7))
      0: return pedm_pkg::GREY_MID;
      1: return 8'd0;
      2: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // offer one item, called and returning at a falling edge; valid stays
  // high on return so the caller either offers the next item or lowers it
  task automatic push_pixel(input logic [7:0] grey, input logic pad);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_grey_level <= grey;
    in_is_pad     <= pad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    pushed_items++;
  endtask

  // stop sending and wait until every predicted result has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [pedm_pkg::IDX_W-1:0] idx,
                           input logic [pedm_pkg::DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_frame(input logic [pedm_pkg::DATA_W-1:0] w_raw,
                           input logic [pedm_pkg::DATA_W-1:0] h_raw);
    cfg_write(pedm_pkg::REG_IMAGE_WIDTH, w_raw);
    cfg_write(pedm_pkg::REG_IMAGE_HEIGHT, h_raw);
    cfg_valid <= 1'b0;
  endtask

  // first cut items of a frame of w x h pixels plus its w+1 flush slots;
  // a few pads fall inside the frame and a few pixels into the flush slots
  task automatic stream_frame(input int w, input int h, input int cut, input int pause_at);
    for (int i = 0; i < cut; i++) begin
      if (i == pause_at) begin
        // drain mid-frame, then poke indexes past the register list:
        // they must leave the frame position alone
        settle();
        cfg_write(pedm_pkg::IDX_W'($urandom_range(2, 15)), pedm_pkg::DATA_W'($urandom));
        cfg_write('1, '1);
        cfg_valid <= 1'b0;
      end
      if (i < w * h) push_pixel(pick_grey(), $urandom_range(19) == 0);
      else push_pixel(pick_grey(), $urandom_range(4) != 0);
    end
  endtask

  initial begin
    int wr;
    int hr;
    int we;
    int he;
    int len;
    int cut;
    int reps;
    int phase_start;
    logic first;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry 640 x 480 with zeroed line stores: a bit past the
    // first row so that the first results come out
    stream_frame(pedm_pkg::RST_WIDTH, pedm_pkg::RST_HEIGHT, 660, -1);
    settle();

    // directed frame with light gaps on both sides
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    set_frame(pedm_pkg::DATA_W'(5), pedm_pkg::DATA_W'(3));
    for (int i = 0; i < 21; i++) push_pixel(DIRECTED_ITEMS[i][7:0], DIRECTED_ITEMS[i][8]);
    settle();

    // widest frame: all-ones width, bit 12 dropped by the register, clamps
    // to the maximum; only its first items, at full rate
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_frame('1, pedm_pkg::DATA_W'(3));
    stream_frame(pedm_pkg::MAX_WIDTH, 3, 64, -1);
    settle();

    // tallest frame, only its start: width reads 2 and clamps up to 3
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    set_frame(pedm_pkg::DATA_W'('h1002), '1);
    stream_frame(3, pedm_pkg::MAX_HEIGHT, 80, -1);

    // random frames in four idle patterns: none, sender gaps, receiver
    // stalls, both; some frames cut short, some run back to back
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
        end
      endcase
      phase_start = pushed_items;
      first = 1'b1;
      while (pushed_items - phase_start < RANDOM_ITEMS / 4) begin
        wr = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
        hr = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
        settle();
        set_frame(pedm_pkg::DATA_W'(wr), pedm_pkg::DATA_W'(hr));
        we   = (wr < pedm_pkg::MIN_DIM) ? pedm_pkg::MIN_DIM : wr;
        he   = (hr < pedm_pkg::MIN_DIM) ? pedm_pkg::MIN_DIM : hr;
        len  = we * he + we + 1;
        reps = $urandom_range(1, 3);
        for (int r = 0; r < reps; r++) begin
          cut = (!first && $urandom_range(5) == 0) ? $urandom_range(1, len - 1) : len;
          // full-rate phase: the receiver holds off while items keep coming,
          // so the core fills up and stalls its input
          if (first && mode == 0) hold_req = 1'b1;
          // mixed phase: the sender pauses halfway until all results are out
          stream_frame(we, he, cut, (first && mode == 3) ? len / 2 : -1);
          first = 1'b0;
          if (cut < len) break;
        end
      end
    end

    settle();
    end_check = 1'b1;
    @(negedge clk);

    $display("run covered %0d items in, %0d results checked, %0d frame ends, %0d reg writes",
             pixels_taken, results_taken, frame_ends, reg_writes);
    $display("widths 3 to 2048, heights 3 to 4096, clamped and ignored writes, stall patterns");
    if (fail_count == 0) begin
      $display("tb_prewitt_edge_direction_masks_core OK");
    end else begin
      $display("tb_prewitt_edge_direction_masks_core NOT OK");
    end
    $finish;
  end

endmodule
